@@ hdl/mrpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mrpc_pkg;

    // Panel geometry
    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int PAGES        = PANEL_HEIGHT / 8;

    // Band store: one entry per byte of a row, seven earlier rows per entry
    localparam int STORE_DEPTH = 16;
    localparam int STORE_LANES = 7;

    // Config register indexes
    localparam logic [1:0] CFG_COL_START = 2'd0;
    localparam logic [1:0] CFG_COL_END   = 2'd1;
    localparam logic [1:0] CFG_TOP_PAGE  = 2'd2;
    localparam logic [1:0] CFG_ROW_COUNT = 2'd3;

    // Panel command opcodes
    localparam logic [7:0] CMD_SET_PAGE = 8'hB0;
    localparam logic [7:0] CMD_COL_LO   = 8'h00;
    localparam logic [7:0] CMD_COL_HI   = 8'h10;
    localparam logic [7:0] NIBBLE_MASK  = 8'h0F;

    // Number of command bytes leading a band
    localparam logic [3:0] CMD_COUNT = 4'd3;

    // One band-end item, ready for the byte emitter
    typedef struct packed {
        logic [7:0]      cmd_page;
        logic [7:0]      cmd_lo;
        logic [7:0]      cmd_hi;
        logic [7:0][7:0] cols;
        logic            has_cmd;
        logic [3:0]      ncols;
        logic            area_done;
    } t_em_desc;

endpackage

`default_nettype wire

@@ hdl/mrpc_emitter.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrpc_emitter (
    input  wire                logic  i_clk,
    input  wire                logic  i_rst_n,
    input  wire                logic  i_load,
    input  wire mrpc_pkg::t_em_desc   i_desc,
    output logic                      o_free,
    input  wire                logic  i_m_tready,
    output logic                      o_m_tvalid,
    output logic [15:0]               o_m_tdata,   // [7:0] byte_value, [8] area_done
    output logic                      o_m_tuser,   // [0] is_data
    output logic                      o_m_tlast    // run_last
);

    mrpc_pkg::t_em_desc r_desc;
    logic       r_busy;
    logic [3:0] r_step;
    logic [3:0] r_last_step;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_user;
    logic       r_last;
    logic       r_area;

    logic       w_adv;
    logic       w_fin;
    logic [3:0] w_base;
    logic [2:0] w_col;
    logic [7:0] w_byte;
    logic       w_is_data;
    logic [3:0] n_last_step;

    assign w_adv  = r_busy && (!r_valid || i_m_tready);
    assign w_fin  = w_adv && (r_step == r_last_step);
    assign o_free = !r_busy || w_fin;

    assign w_base      = r_desc.has_cmd ? mrpc_pkg::CMD_COUNT : 4'd0;
    assign w_col       = 3'(r_step - w_base);
    assign n_last_step = (i_desc.has_cmd ? mrpc_pkg::CMD_COUNT : 4'd0) + i_desc.ncols - 4'd1;

    always_comb begin
        w_is_data = 1'b1;
        w_byte    = r_desc.cols[w_col];
        if (r_desc.has_cmd && (r_step < mrpc_pkg::CMD_COUNT)) begin
            w_is_data = 1'b0;
            case (r_step[1:0])
                2'd0:    w_byte = r_desc.cmd_page;
                2'd1:    w_byte = r_desc.cmd_lo;
                default: w_byte = r_desc.cmd_hi;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy      <= 1'b1;
                r_step      <= 4'd0;
                r_last_step <= n_last_step;
                r_desc      <= i_desc;
            end else if (w_fin) begin
                r_busy <= 1'b0;
            end else if (w_adv) begin
                r_step <= r_step + 4'd1;
            end

            if (w_adv) begin
                r_valid <= 1'b1;
                r_byte  <= w_byte;
                r_user  <= w_is_data;
                r_last  <= (r_step == r_last_step);
                r_area  <= (r_step == r_last_step) && r_desc.area_done;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {7'd0, r_area, r_byte};
    assign o_m_tuser  = r_user;
    assign o_m_tlast  = r_last;

endmodule

`default_nettype wire

@@ hdl/mono_rows_to_page_columns.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Converts a 1-bit, MSB-first, row-major pixel window into vertical page bytes.
// Input stream (s_*): one pixel byte per transfer, rows padded to whole bytes.
// Bytes of rows that do not end an 8-row band go into the band store and give
// no output. A byte of a band's last row reads the earlier rows of its column
// group and produces up to eight column bytes (bit b = band row b); the first
// byte of such a row is led by page, column-low and column-high commands.
// Output stream (m_*): tuser = 1 for display data, 0 for a command byte; tlast
// marks the last transfer caused by one input byte; tdata[8] marks the last
// byte of the window.
// Throughput: one input byte per cycle while only storing and the staging register
// is free; a band-end byte's 1 to 11 output transfers, one per cycle while the
// receiver is ready, set the rate. It passes the staging, descriptor and output
// registers. An input byte is still taken while the emitter drains the previous
// one. Receiver stall: the emitter holds its output register, then the staging
// register fills and s_tready drops. Reset clears counters and config to defaults;
// the band store needs no clearing. A config write restarts the window.
module mono_rows_to_page_columns (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    // Input stream
    input  wire  logic        i_s_tvalid,
    output logic              o_s_tready,
    input  wire  logic [7:0]  i_s_tdata,   // [7:0] pixel_byte
    // Output stream
    output logic              o_m_tvalid,
    input  wire  logic        i_m_tready,
    output logic [15:0]       o_m_tdata,   // [7:0] byte_value, [8] area_done
    output logic              o_m_tuser,   // [0] is_data
    output logic              o_m_tlast,   // run_last
    // Config write port
    input  wire  logic        i_cfg_we,
    input  wire  logic [1:0]  i_cfg_idx,
    input  wire  logic [6:0]  i_cfg_data
);

    localparam int DEPTH = mrpc_pkg::STORE_DEPTH;
    localparam int LANES = mrpc_pkg::STORE_LANES;

    // Config registers
    logic [6:0] r_col_start;
    logic [6:0] r_col_end;
    logic [2:0] r_top_page;
    logic [6:0] r_row_count;

    // Window position
    logic [6:0] r_row_cnt;
    logic [3:0] r_byte_cnt;

    // Band store and its registered read port
    logic [LANES-1:0][7:0] mem [DEPTH];
    logic [LANES-1:0][7:0] r_mem_q;

    // Staging register for a band-end byte
    logic       r_s1_valid;
    logic [7:0] r_s1_px;
    logic [2:0] r_s1_rb;
    logic       r_s1_cmd;
    logic [3:0] r_s1_page;
    logic [3:0] r_s1_ncols;
    logic       r_s1_area;

    logic       w_accept;
    logic       w_s1_load;
    logic       w_em_free;
    logic [6:0] w_diff;
    logic [7:0] w_width_raw;
    logic [7:0] w_width;
    logic [4:0] w_stride;
    logic [6:0] w_rows;
    logic [2:0] w_rb;
    logic       w_last_row;
    logic       w_last_byte;
    logic       w_band_end;
    logic [4:0] w_page_sum;
    logic [3:0] w_page_tbl [32];
    logic [7:0] w_rem;
    logic [3:0] w_ncols;
    mrpc_pkg::t_em_desc w_desc;

    // Window geometry
    assign w_diff      = r_col_end - r_col_start;
    assign w_width_raw = {1'b0, w_diff} + 8'd1;
    assign w_width     = (9'(w_width_raw) > 9'(mrpc_pkg::PANEL_WIDTH)) ?
                         8'(mrpc_pkg::PANEL_WIDTH) : w_width_raw;
    assign w_stride    = 5'((9'(w_width) + 9'd7) >> 3);
    assign w_rows      = (r_row_count == 7'd0) ? 7'd1 : r_row_count;

    assign w_rb        = r_row_cnt[2:0];
    assign w_last_row  = ({1'b0, r_row_cnt} + 8'd1) >= {1'b0, w_rows};
    assign w_last_byte = ({1'b0, r_byte_cnt} + 5'd1) >= w_stride;
    assign w_band_end  = (w_rb == 3'd7) || w_last_row;

    // Columns covered by this byte; the last byte of a row may be partial
    assign w_rem   = w_width - {1'b0, r_byte_cnt, 3'b000};
    assign w_ncols = (w_rem > 8'd8) ? 4'd8 : w_rem[3:0];

    // Page number wraps at the panel height; small constant table
    assign w_page_sum = 5'(r_top_page) + 5'(r_row_cnt[6:3]);
    for (genvar g = 0; g < 32; g++) begin : g_page
        assign w_page_tbl[g] = 4'(g % mrpc_pkg::PAGES);
    end

    // Handshake
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_s1_load  = r_s1_valid && w_em_free;
    assign o_s_tready = !r_s1_valid || w_s1_load;

    // Config and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_start <= 7'd0;
            r_col_end   <= 7'd127;
            r_top_page  <= 3'd0;
            r_row_count <= 7'd64;
            r_row_cnt   <= 7'd0;
            r_byte_cnt  <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mrpc_pkg::CFG_COL_START: r_col_start <= i_cfg_data;
                mrpc_pkg::CFG_COL_END:   r_col_end   <= i_cfg_data;
                mrpc_pkg::CFG_TOP_PAGE:  r_top_page  <= i_cfg_data[2:0];
                mrpc_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                default:                 r_row_count <= i_cfg_data;
            endcase
            r_row_cnt  <= 7'd0;
            r_byte_cnt <= 4'd0;
        end else if (w_accept) begin
            if (w_last_byte) begin
                r_byte_cnt <= 4'd0;
                r_row_cnt  <= w_last_row ? 7'd0 : r_row_cnt + 7'd1;
            end else begin
                r_byte_cnt <= r_byte_cnt + 4'd1;
            end
        end
    end

    // Band store: lane write for stored rows, entry read for every transfer.
    // Read and write of one entry by later transfers land on later edges.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (!w_band_end) begin
                mem[r_byte_cnt][w_rb] <= i_s_tdata;
            end
            r_mem_q <= mem[r_byte_cnt];
        end
    end

    // Staging register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= w_band_end;
        end else if (w_s1_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_band_end) begin
            r_s1_px    <= i_s_tdata;
            r_s1_rb    <= w_rb;
            r_s1_cmd   <= (r_byte_cnt == 4'd0);
            r_s1_page  <= w_page_tbl[w_page_sum];
            r_s1_ncols <= w_ncols;
            r_s1_area  <= w_last_row && w_last_byte;
        end
    end

    // Transpose: column j takes pixel 7-j of each band row
    always_comb begin
        w_desc.cmd_page  = mrpc_pkg::CMD_SET_PAGE + {4'd0, r_s1_page};
        w_desc.cmd_lo    = mrpc_pkg::CMD_COL_LO |
                           ({1'b0, r_col_start} & mrpc_pkg::NIBBLE_MASK);
        w_desc.cmd_hi    = mrpc_pkg::CMD_COL_HI | {5'd0, r_col_start[6:4]};
        w_desc.has_cmd   = r_s1_cmd;
        w_desc.ncols     = r_s1_ncols;
        w_desc.area_done = r_s1_area;
        for (int j = 0; j < 8; j++) begin
            w_desc.cols[j] = {7'd0, r_s1_px[7-j]} << r_s1_rb;
            for (int b = 0; b < LANES; b++) begin
                if (3'(b) < r_s1_rb) begin
                    w_desc.cols[j][b] = r_mem_q[b][7-j];
                end
            end
        end
    end

    mrpc_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_s1_load),
        .i_desc     (w_desc),
        .o_free     (w_em_free),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // A staged byte that cannot move keeps its store read data; unused
    // lanes may be unknown, so the compare is exact
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_load |=> r_s1_valid && (r_mem_q === $past(r_mem_q)))
        else $error("staged band-end byte lost its store data");

    // Every run ends in a column byte, never a command
    a_cmd_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> !o_m_tlast)
        else $error("command byte closed a run");

    // Byte position stays inside the row
    a_byte_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_byte_cnt} < w_stride)
        else $error("byte counter ran past the row stride");

    // Window end is only flagged on the last transfer of a run
    a_area_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[8] |-> o_m_tlast && o_m_tuser)
        else $error("window end flagged mid-run");

endmodule

`default_nettype wire
